[rtl/tls_pkg.sv]
// Shared types, codes and a helper function for the traffic light sequencer.
package tls_pkg;

  // Lamp patterns: bit0 red1, bit1 green1, bit2 yellow1, bit3 red2, bit4 green2, bit5 yellow2.
  localparam logic [5:0] LampR1G2  = 6'h11;
  localparam logic [5:0] LampY2R1  = 6'h21;
  localparam logic [5:0] LampR2G1  = 6'h0A;
  localparam logic [5:0] LampY1R2  = 6'h0C;
  localparam logic [5:0] LampFlash = 6'h24;
  localparam logic [5:0] LampOff   = 6'h00;

  // Configuration register indexes and their reset values.
  localparam logic [1:0] CfgGreenTime   = 2'd0;
  localparam logic [1:0] CfgYellowTime  = 2'd1;
  localparam logic [1:0] CfgSecondTicks = 2'd2;
  localparam logic [5:0] GreenTimeRst   = 6'd10;
  localparam logic [4:0] YellowTimeRst  = 5'd3;
  localparam logic [5:0] SecondTicksRst = 6'd25;

  typedef enum logic [2:0] {
    PhStart      = 3'd0,
    PhR1G2       = 3'd1,
    PhY2R1       = 3'd2,
    PhR2G1       = 3'd3,
    PhY1R2       = 3'd4,
    PhFlashStart = 3'd5,
    PhFlashOn    = 3'd6,
    PhFlashOff   = 3'd7
  } tls_phase_e;

  typedef struct packed {
    logic [5:0] green_time;
    logic [4:0] yellow_time;
    logic [5:0] second_ticks;
  } tls_cfg_t;

  typedef struct packed {
    tls_phase_e phase;
    logic [5:0] tick_count;
    logic [6:0] red_length;
    logic [6:0] red_elapsed;
    logic [6:0] green_elapsed;
    logic [5:0] yellow_elapsed;
    logic [5:0] lamps;
    logic [7:0] display_a;
    logic [7:0] display_b;
  } tls_state_t;

  // Remaining seconds as two BCD digits, clamped to the range 0 to 99.
  function automatic logic [7:0] to_bcd(input logic [6:0] total, input logic [6:0] used);
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    rem = (used >= total) ? 7'd0 : 7'(total - used);
    if (rem > 7'd99) rem = 7'd99;
    // Division by ten through a reciprocal multiply, exact below 160.
    prod = 15'(rem) * 15'd205;
    tens = prod[14:11];
    ones = 7'(rem - 7'(tens) * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

[rtl/tls_step.sv]
// Next-state logic for one scan tick of the traffic light sequencer.
module tls_step (
  input  tls_pkg::tls_cfg_t   cfg_i,
  input  tls_pkg::tls_state_t cur_i,
  input  logic                button_i,
  output tls_pkg::tls_state_t nxt_o
);
  import tls_pkg::*;

  logic [6:0] tick_inc;
  logic       tick_wrap;
  logic [5:0] tick_next;
  logic       is_green;
  logic       green_done;
  logic       yellow_done;
  logic       sec;
  logic [7:0] own_bcd;
  logic [7:0] red_bcd;

  // Tick counter: the incremented count is compared before it is stored.
  assign tick_inc  = {1'b0, cur_i.tick_count} + 7'd1;
  assign tick_wrap = tick_inc > {1'b0, cfg_i.second_ticks};
  assign tick_next = tick_wrap ? 6'd0 : tick_inc[5:0];

  // Countdown values from the counters as they stood before this tick.
  assign is_green    = (cur_i.phase == PhR1G2) || (cur_i.phase == PhR2G1);
  assign own_bcd     = is_green ? to_bcd({1'b0, cfg_i.green_time}, cur_i.green_elapsed)
                                : to_bcd({2'b0, cfg_i.yellow_time}, {1'b0, cur_i.yellow_elapsed});
  assign red_bcd     = to_bcd(cur_i.red_length, cur_i.red_elapsed);
  assign green_done  = is_green && (cur_i.green_elapsed > {1'b0, cfg_i.green_time});
  assign yellow_done = !is_green && (cur_i.yellow_elapsed > {1'b0, cfg_i.yellow_time});

  always_comb begin
    nxt_o = cur_i;
    sec   = 1'b0;
    case (cur_i.phase)
      PhStart: begin
        nxt_o.red_length     = 7'({1'b0, cfg_i.green_time} + {2'b0, cfg_i.yellow_time} + 7'd1);
        nxt_o.red_elapsed    = '0;
        nxt_o.green_elapsed  = '0;
        nxt_o.yellow_elapsed = '0;
        nxt_o.phase          = PhR1G2;
      end
      PhR1G2, PhY2R1, PhR2G1, PhY1R2: begin
        case (cur_i.phase)
          PhR1G2:  nxt_o.lamps = LampR1G2;
          PhY2R1:  nxt_o.lamps = LampY2R1;
          PhR2G1:  nxt_o.lamps = LampR2G1;
          default: nxt_o.lamps = LampY1R2;
        endcase
        if ((cur_i.phase == PhR1G2) || (cur_i.phase == PhY2R1)) begin
          nxt_o.display_a = red_bcd;
          nxt_o.display_b = own_bcd;
        end else begin
          nxt_o.display_a = own_bcd;
          nxt_o.display_b = red_bcd;
        end
        nxt_o.tick_count = tick_next;
        sec              = tick_wrap;
        // End of phase takes priority over the second boundary.
        if (green_done) begin
          nxt_o.tick_count    = '0;
          nxt_o.green_elapsed = '0;
          nxt_o.phase         = (cur_i.phase == PhR1G2) ? PhY2R1 : PhY1R2;
          sec                 = 1'b0;
        end else if (yellow_done) begin
          nxt_o.tick_count     = '0;
          nxt_o.red_elapsed    = '0;
          nxt_o.yellow_elapsed = '0;
          nxt_o.phase          = (cur_i.phase == PhY2R1) ? PhR2G1 : PhStart;
          sec                  = 1'b0;
        end
        // Elapsed counters saturate at their maxima.
        if (sec) begin
          if (cur_i.red_elapsed != 7'h7F) nxt_o.red_elapsed = cur_i.red_elapsed + 7'd1;
          if (is_green) begin
            if (cur_i.green_elapsed != 7'h7F) nxt_o.green_elapsed = cur_i.green_elapsed + 7'd1;
          end else begin
            if (cur_i.yellow_elapsed != 6'h3F) nxt_o.yellow_elapsed = cur_i.yellow_elapsed + 6'd1;
          end
        end
        if (button_i) nxt_o.phase = PhFlashStart;
      end
      PhFlashStart: begin
        nxt_o.tick_count = '0;
        nxt_o.phase      = PhFlashOn;
      end
      default: begin
        // Flash on and flash off toggle once a second.
        nxt_o.lamps      = (cur_i.phase == PhFlashOn) ? LampFlash : LampOff;
        nxt_o.tick_count = tick_next;
        if (tick_wrap) nxt_o.phase = (cur_i.phase == PhFlashOn) ? PhFlashOff : PhFlashOn;
        if (button_i) nxt_o.phase = PhStart;
      end
    endcase
  end

endmodule

[rtl/traffic_light_sequencer_core.sv]
// Pipeline: a word accepted on the input is held in the input register, and its step
// result is captured in the output register, from which it is presented.
// Throughput: one word per cycle; the next-state logic and the output register
// set that figure, and a full output register stalls the input register behind it.
// Reset: asynchronous, active low; clears the sequencer state to cycle start with
// all lamps off and loads the configuration defaults 10, 3 and 25.
module traffic_light_sequencer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [5:0]  cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [0] mode_button, [7:1] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // [5:0] lamps, [13:6] display_a,
                                       // [21:14] display_b, [24:22] phase, [31:25] zero
);
  import tls_pkg::*;

  tls_cfg_t   cfg_q;
  tls_state_t state_q;
  tls_state_t state_d;
  logic       in_valid_q;
  logic       in_button_q;
  logic       out_valid_q;
  logic [5:0] out_lamps_q;
  logic [7:0] out_disp_a_q;
  logic [7:0] out_disp_b_q;
  logic [2:0] out_phase_q;
  logic       step_go;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_time   <= GreenTimeRst;
      cfg_q.yellow_time  <= YellowTimeRst;
      cfg_q.second_ticks <= SecondTicksRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgGreenTime:   cfg_q.green_time   <= cfg_data_i;
        CfgYellowTime:  cfg_q.yellow_time  <= cfg_data_i[4:0];
        CfgSecondTicks: cfg_q.second_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: a word steps when the output register is free or being emptied.
  assign step_go         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step_go;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) in_button_q <= s_axis_tdata_i[0];
  end

  tls_step u_step (
    .cfg_i    (cfg_q),
    .cur_i    (state_q),
    .button_i (in_button_q),
    .nxt_o    (state_d)
  );

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PhStart, default: '0};
    end else if (step_go) begin
      state_q <= state_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= step_go || (out_valid_q && !m_axis_tready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      out_lamps_q  <= state_d.lamps;
      out_disp_a_q <= state_d.display_a;
      out_disp_b_q <= state_d.display_b;
      out_phase_q  <= state_d.phase;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_phase_q, out_disp_b_q, out_disp_a_q, out_lamps_q};

endmodule

[rtl/tls_checker.sv]
// Port-level checker for the traffic light sequencer, bound to the top level.
module tls_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);
  import tls_pkg::*;

  logic       out_take;
  logic       seen_q;
  logic [2:0] last_phase_q;
  logic [2:0] out_phase;
  logic [5:0] out_lamps;

  assign out_take  = m_axis_tvalid_o && m_axis_tready_i;
  assign out_phase = m_axis_tdata_o[24:22];
  assign out_lamps = m_axis_tdata_o[5:0];

  // Phase of the previous delivered word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q       <= 1'b0;
      last_phase_q <= PhStart;
    end else if (out_take) begin
      seen_q       <= 1'b1;
      last_phase_q <= out_phase;
    end
  end

  // A stalled word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output word changed while stalled");

  // Both displays carry valid BCD digits on every valid word.
  a_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[9:6] <= 4'd9) && (m_axis_tdata_o[13:10] <= 4'd9) &&
                        (m_axis_tdata_o[17:14] <= 4'd9) && (m_axis_tdata_o[21:18] <= 4'd9))
    else $error("display digit out of BCD range");

  // Flash phases drive their own lamp patterns, except on the word straight after flash
  // start, which still shows the lamps of the colour phase that was left.
  a_flash_lamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && seen_q && (last_phase_q != PhFlashStart) &&
      (out_phase == PhFlashOn || out_phase == PhFlashOff) |->
      (out_lamps == LampFlash || out_lamps == LampOff))
    else $error("flash phase with wrong lamps");

  // Cycle start and flash start each lead to one fixed phase.
  a_phase_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && seen_q && (last_phase_q == PhStart || last_phase_q == PhFlashStart) |->
      (last_phase_q == PhStart) ? (out_phase == PhR1G2) : (out_phase == PhFlashOn))
    else $error("illegal phase sequence");

endmodule

bind traffic_light_sequencer_core tls_checker u_tls_checker (.*);
